// ===== hdl/mbsp_pkg.sv =====
// Shared types, constants and the status length lookup for the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

   localparam int SYSEX_SIZE = 8192;
   localparam int SYSEX_CNT_W = $clog2(SYSEX_SIZE + 1);
   localparam logic [SYSEX_CNT_W-1:0] SYSEX_KEEP_LIMIT = SYSEX_CNT_W'(SYSEX_SIZE - 1);

   localparam logic [7:0] REALTIME_MIN = 8'hF8;
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] SYSEX_STOP   = 8'hF7;
   localparam logic [7:0] CHAN_PAIR_MIN = 8'hC0;
   localparam logic [7:0] CHAN_TRIO_MIN = 8'hE0;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // The queue depth must be a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] SYS_LEN_TABLE [0:15] = '{
      2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
      2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
   };

   typedef enum logic [1:0] {
      KIND_SHORT    = 2'd0,
      KIND_REALTIME = 2'd1,
      KIND_SYSEX    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic [1:0] msg_len;
      logic [7:0] sysex_byte;
      logic       sysex_end;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [1:0] res;
   } parse_out_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] fill;
      logic                   room;
   } queue_status_type;

   function automatic logic [1:0] len_of(input logic [7:0] st);
      logic [1:0] len;
      if (!st[7]) begin
         len = 2'd0;
      end else if (st < CHAN_PAIR_MIN) begin
         len = 2'd3;
      end else if (st < CHAN_TRIO_MIN) begin
         len = 2'd2;
      end else if (st < SYSEX_START) begin
         len = 2'd3;
      end else begin
         len = SYS_LEN_TABLE[st[3:0]];
      end
      return len;
   endfunction

endpackage

// ===== hdl/mbsp_parser.sv =====
// Parser state and the single-pass decode of one byte into up to two results.
`timescale 1ns / 1ps

module mbsp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             byte_in,
   output mbsp_pkg::parse_out_type parse_out
);

   logic [7:0]                       running_status_ff, running_status_in;
   logic [1:0]                       expected_len_ff, expected_len_in;
   logic [1:0]                       fill_pos_ff, fill_pos_in;
   logic [7:0]                       msg_store_ff [3];
   logic [7:0]                       msg_store_in [3];
   logic [mbsp_pkg::SYSEX_CNT_W-1:0] sysex_count_ff, sysex_count_in;

   logic                  is_realtime;
   logic                  in_sysex;
   logic                  is_status;
   logic [1:0]            eff_len;
   logic [1:0]            eff_pos;
   logic [2:0]            next_pos;
   logic                  second_valid;
   mbsp_pkg::result_type  second_res;
   mbsp_pkg::result_type  end_res;

   always_comb begin
      running_status_in = running_status_ff;
      expected_len_in   = expected_len_ff;
      fill_pos_in       = fill_pos_ff;
      msg_store_in      = msg_store_ff;
      sysex_count_in    = sysex_count_ff;
      parse_out         = '0;
      second_valid      = 1'b0;
      second_res        = '0;
      end_res           = '0;
      eff_len           = expected_len_ff;
      eff_pos           = fill_pos_ff;
      next_pos          = '0;

      is_realtime = byte_in >= mbsp_pkg::REALTIME_MIN;
      in_sysex    = running_status_ff == mbsp_pkg::SYSEX_START;
      is_status   = byte_in[7];

      end_res.kind        = mbsp_pkg::KIND_SYSEX;
      end_res.status_byte = mbsp_pkg::SYSEX_START;
      end_res.sysex_byte  = mbsp_pkg::SYSEX_STOP;
      end_res.sysex_end   = 1'b1;

      if (is_realtime) begin
         parse_out.count              = 2'd1;
         parse_out.res[0].kind        = mbsp_pkg::KIND_REALTIME;
         parse_out.res[0].status_byte = byte_in;
         parse_out.res[0].msg_len     = 2'd1;
         parse_out.res[0].last        = 1'b1;
      end else if (in_sysex && !is_status) begin
         if (sysex_count_ff < mbsp_pkg::SYSEX_KEEP_LIMIT) begin
            sysex_count_in               = sysex_count_ff + mbsp_pkg::SYSEX_CNT_W'(1);
            parse_out.count              = 2'd1;
            parse_out.res[0].kind        = mbsp_pkg::KIND_SYSEX;
            parse_out.res[0].status_byte = mbsp_pkg::SYSEX_START;
            parse_out.res[0].sysex_byte  = byte_in;
            parse_out.res[0].last        = 1'b1;
         end
      end else begin
         if (in_sysex) begin
            sysex_count_in = sysex_count_ff + mbsp_pkg::SYSEX_CNT_W'(1);
         end
         if (is_status) begin
            eff_len           = mbsp_pkg::len_of(byte_in);
            eff_pos           = 2'd0;
            running_status_in = byte_in;
            expected_len_in   = eff_len;
            fill_pos_in       = 2'd0;
            if (byte_in == mbsp_pkg::SYSEX_START) begin
               sysex_count_in         = mbsp_pkg::SYSEX_CNT_W'(1);
               second_valid           = 1'b1;
               second_res.kind        = mbsp_pkg::KIND_SYSEX;
               second_res.status_byte = mbsp_pkg::SYSEX_START;
               second_res.sysex_byte  = mbsp_pkg::SYSEX_START;
            end
         end
         if (eff_len != 2'd0) begin
            if (eff_pos != 2'd3) begin
               msg_store_in[eff_pos] = byte_in;
            end
            next_pos    = {1'b0, eff_pos} + 3'd1;
            fill_pos_in = next_pos[1:0];
            if (next_pos >= {1'b0, eff_len}) begin
               second_valid           = 1'b1;
               second_res.kind        = mbsp_pkg::KIND_SHORT;
               second_res.status_byte = msg_store_in[0];
               second_res.data_one    = msg_store_in[1];
               second_res.data_two    = msg_store_in[2];
               second_res.msg_len     = eff_len;
               fill_pos_in            = 2'd1;
            end
         end
         if (in_sysex) begin
            parse_out.res[0] = end_res;
            parse_out.res[1] = second_res;
            parse_out.count  = second_valid ? 2'd2 : 2'd1;
         end else begin
            parse_out.res[0] = second_res;
            parse_out.count  = second_valid ? 2'd1 : 2'd0;
         end
         if (parse_out.count == 2'd2) begin
            parse_out.res[1].last = 1'b1;
         end else if (parse_out.count == 2'd1) begin
            parse_out.res[0].last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         expected_len_ff   <= '0;
         fill_pos_ff       <= '0;
         msg_store_ff      <= '{default: '0};
         sysex_count_ff    <= '0;
      end else if (advance) begin
         running_status_ff <= running_status_in;
         expected_len_ff   <= expected_len_in;
         fill_pos_ff       <= fill_pos_in;
         msg_store_ff      <= msg_store_in;
         sysex_count_ff    <= sysex_count_in;
      end
   end

endmodule

// ===== hdl/mbsp_out_queue.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module mbsp_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_en,
   input  mbsp_pkg::parse_out_type   push_data,
   input  logic                      pop,
   output logic                      head_valid,
   output mbsp_pkg::result_type      head,
   output mbsp_pkg::queue_status_type status
);

   mbsp_pkg::result_type              entries_ff [mbsp_pkg::QUEUE_DEPTH];
   logic [mbsp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mbsp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mbsp_pkg::QUEUE_CNT_W-1:0]  fill_ff, fill_in;
   logic [1:0]                        push_count;
   logic [mbsp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next_slot;

   assign push_count       = push_en ? push_data.count : 2'd0;
   assign wr_ptr_next_slot = wr_ptr_ff + mbsp_pkg::QUEUE_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mbsp_pkg::QUEUE_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + mbsp_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + mbsp_pkg::QUEUE_CNT_W'(push_count)
                  - mbsp_pkg::QUEUE_CNT_W'(pop);
   end

   assign head_valid  = fill_ff != '0;
   assign head        = entries_ff[rd_ptr_ff];
   assign status.fill = fill_ff;
   assign status.room = fill_ff <= mbsp_pkg::QUEUE_CNT_W'(mbsp_pkg::QUEUE_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.res[0];
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_next_slot] <= push_data.res[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== hdl/midi_byte_stream_parser.sv =====
// Top level of the MIDI byte stream parser: input register, parser and result queue.
// An accepted word is held in the input register, decoded by the parser and queued for rsp.
// Throughput: one input word per cycle while the queue has room; a byte that closes a system
// exclusive message and starts a new one or carries a one-byte message yields two result words.
// The four-entry result queue sets how far the output side may stall before req_tready drops.
// Reset clears running status, lengths, the message store, the sysex count and the queue.
`timescale 1ns / 1ps

module midi_byte_stream_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mbsp_pkg::REQ_TDATA_W-1:0] req_tdata,  // [7:0] byte_in
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] status_byte, [15:8] data_one, [23:16] data_two, [25:24] msg_len,
   // [33:26] sysex_byte, [34] sysex_end, [39:35] zero
   output logic [mbsp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [mbsp_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [1:0] kind
   output logic                             rsp_tlast
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff, in_byte_in;
   logic                        advance;
   logic                        req_accept;
   logic                        rsp_accept;
   mbsp_pkg::parse_out_type     parse_out;
   mbsp_pkg::result_type        head;
   mbsp_pkg::queue_status_type  q_status;

   assign advance    = in_valid_ff && q_status.room;
   assign req_tready = !in_valid_ff || q_status.room;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   mbsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_in   (in_byte_ff),
      .parse_out (parse_out)
   );

   mbsp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (advance),
      .push_data  (parse_out),
      .pop        (rsp_accept),
      .head_valid (rsp_tvalid),
      .head       (head),
      .status     (q_status)
   );

   assign rsp_tdata = {5'b0, head.sysex_end, head.sysex_byte, head.msg_len,
                       head.data_two, head.data_one, head.status_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.fill <= mbsp_pkg::QUEUE_CNT_W'(mbsp_pkg::QUEUE_DEPTH))
      else $error("Result queue holds more words than it has entries.");

   a_pair_starts_with_close: assert property (@(posedge clock) disable iff (reset)
      (advance && parse_out.count == 2'd2) |-> parse_out.res[0].sysex_end)
      else $error("Two results from one byte without a sysex close first.");

   a_realtime_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.kind == mbsp_pkg::KIND_REALTIME)
         |-> (head.last && head.msg_len == 2'd1))
      else $error("Realtime word is not a single one-byte message.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && !q_status.room))
      else $error("Input stalled while the queue had room.");

endmodule

// ===== tb/sv/tb_midi_byte_stream_parser.sv =====
// Self-checking testbench for the MIDI byte stream parser with a running-status scoreboard.
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser;

   class midi_scoreboard;
      logic [7:0]           run_status;
      logic [1:0]           want_len;
      logic [1:0]           fill_pos;
      logic [7:0]           store [3];
      int                   sysex_bytes;
      mbsp_pkg::result_type pending [$];
      int                   errors;
      int                   shown;
      int                   accepted;
      int                   checked;
      int                   dropped;

      function new();
         run_status = '0;
         want_len = '0;
         fill_pos = '0;
         foreach (store[i]) store[i] = '0;
         sysex_bytes = 0;
         errors = 0;
         shown = 0;
         accepted = 0;
         checked = 0;
         dropped = 0;
      endfunction

      static function logic [1:0] len_for(input logic [7:0] s);
         if (!s[7]) return 2'd0;
         if (s < 8'hC0) return 2'd3;
         if (s < 8'hE0) return 2'd2;
         if (s < mbsp_pkg::SYSEX_START) return 2'd3;
         case (s[3:0])
            4'h1, 4'h3: return 2'd2;
            4'h2: return 2'd3;
            4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE: return 2'd1;
            default: return 2'd0;
         endcase
      endfunction

      function mbsp_pkg::result_type make(input mbsp_pkg::kind_type k, input logic [7:0] st,
                                          input logic [7:0] d1, input logic [7:0] d2,
                                          input logic [1:0] len, input logic [7:0] sx,
                                          input logic sx_end);
         mbsp_pkg::result_type r;
         r.kind = k;
         r.status_byte = st;
         r.data_one = d1;
         r.data_two = d2;
         r.msg_len = len;
         r.sysex_byte = sx;
         r.sysex_end = sx_end;
         r.last = 1'b0;
         return r;
      endfunction

      function string show(input mbsp_pkg::result_type r);
         return $sformatf("kind %0d st %h d1 %h d2 %h len %0d sx %h end %b last %b",
                          r.kind, r.status_byte, r.data_one, r.data_two, r.msg_len,
                          r.sysex_byte, r.sysex_end, r.last);
      endfunction

      function void report(input string msg);
         errors++;
         if (shown < 10) begin
            shown++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endfunction

      function void note_byte(input logic [7:0] b);
         mbsp_pkg::result_type out [$];
         logic [2:0]           pos;
         accepted++;
         if (b >= mbsp_pkg::REALTIME_MIN) begin
            out.push_back(make(mbsp_pkg::KIND_REALTIME, b, 8'h00, 8'h00, 2'd1, 8'h00, 1'b0));
         end else if (run_status == mbsp_pkg::SYSEX_START && !b[7]) begin
            if (sysex_bytes < mbsp_pkg::SYSEX_SIZE - 1) begin
               sysex_bytes++;
               out.push_back(make(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START, 8'h00, 8'h00,
                                  2'd0, b, 1'b0));
            end else begin
               dropped++;
            end
         end else begin
            if (run_status == mbsp_pkg::SYSEX_START) begin
               sysex_bytes++;
               out.push_back(make(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START, 8'h00, 8'h00,
                                  2'd0, mbsp_pkg::SYSEX_STOP, 1'b1));
            end
            if (b[7]) begin
               run_status = b;
               fill_pos = 2'd0;
               want_len = len_for(b);
               if (b == mbsp_pkg::SYSEX_START) begin
                  sysex_bytes = 1;
                  out.push_back(make(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START, 8'h00,
                                     8'h00, 2'd0, mbsp_pkg::SYSEX_START, 1'b0));
               end
            end
            if (want_len != 2'd0) begin
               pos = {1'b0, fill_pos};
               if (pos < 3'd3) store[pos] = b;
               pos = pos + 3'd1;
               fill_pos = pos[1:0];
               if (pos >= {1'b0, want_len}) begin
                  out.push_back(make(mbsp_pkg::KIND_SHORT, store[0], store[1], store[2],
                                     want_len, 8'h00, 1'b0));
                  fill_pos = 2'd1;
               end
            end
         end
         if (out.size() > 0) begin
            out[out.size() - 1].last = 1'b1;
         end
         foreach (out[i]) pending.push_back(out[i]);
      endfunction

      function void check_word(input logic [mbsp_pkg::RSP_TDATA_W-1:0] tdata,
                               input logic [mbsp_pkg::RSP_TUSER_W-1:0] tuser,
                               input logic tlast);
         mbsp_pkg::result_type got;
         mbsp_pkg::result_type want;
         got.kind = mbsp_pkg::kind_type'(tuser);
         got.status_byte = tdata[7:0];
         got.data_one = tdata[15:8];
         got.data_two = tdata[23:16];
         got.msg_len = tdata[25:24];
         got.sysex_byte = tdata[33:26];
         got.sysex_end = tdata[34];
         got.last = tlast;
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result word: %s", show(got)));
         end else begin
            want = pending.pop_front();
            if (got !== want || tdata[39:35] !== 5'd0) begin
               report($sformatf("expected %s, got %s pad %b", show(want), show(got),
                                tdata[39:35]));
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [mbsp_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [mbsp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [mbsp_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             rsp_tlast;

   midi_scoreboard sb;
   bit             idle_on;
   bit             hold_request;
   int             hold_count;

   midi_byte_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
   endtask

   task automatic send_data(input logic [7:0] b);
      if ($urandom_range(0, 99) < 8) send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      send_byte(b);
   endtask

   task automatic send_random_sequence();
      int         r;
      int         n;
      logic [7:0] st;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         st = 8'($urandom_range(8'h80, 8'hEF));
         send_byte(st);
         repeat ($urandom_range(1, 3)) begin
            n = int'(midi_scoreboard::len_for(st)) - 1;
            repeat (n) send_data(8'($urandom_range(0, 127)));
         end
      end else if (r < 55) begin
         send_byte(mbsp_pkg::SYSEX_START);
         repeat ($urandom_range(0, 12)) send_data(8'($urandom_range(0, 127)));
         if ($urandom_range(0, 99) < 70) send_byte(mbsp_pkg::SYSEX_STOP);
         else send_byte(8'($urandom_range(8'h80, 8'hF7)));
      end else if (r < 70) begin
         st = 8'($urandom_range(8'hF1, 8'hF7));
         send_byte(st);
         n = int'(midi_scoreboard::len_for(st)) - 1;
         if (n < 1) n = 1;
         repeat (n) send_data(8'($urandom_range(0, 127)));
      end else if (r < 80) begin
         send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int         stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_count++;
            stall_left = 80;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [7:0] directed [];
      int seq_index;
      int wait_cycles;
      directed = '{
         8'h00, 8'h7F, 8'h90, 8'h3C, 8'h7F, 8'h40, 8'h00, 8'hC5, 8'h12, 8'hF8, 8'hFF,
         8'hF6, 8'h55, 8'hF2, 8'h01, 8'h02, 8'hF4, 8'h55, 8'hF0, 8'h7E, 8'hFA, 8'h01,
         8'hF0, 8'h11, 8'hF6, 8'hF0, 8'h22, 8'hF7, 8'hEF, 8'h00, 8'h7F, 8'hF0, 8'h80,
         8'h01, 8'h02
      };
      sb = new();
      idle_on = 1'b1;
      hold_request = 1'b0;
      hold_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_byte(directed[i]);

      seq_index = 0;
      while (sb.accepted < 450) begin
         idle_on = ((seq_index / 30) % 3) != 2;
         if (seq_index == 65) hold_request = 1'b1;
         send_random_sequence();
         seq_index++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      wait_cycles = sb.pending.size();
      if (wait_cycles != 0) sb.report($sformatf("%0d results never arrived", wait_cycles));

      $display("Run covered %0d input bytes and %0d result words, %0d sysex bytes dropped",
               sb.accepted, sb.checked, sb.dropped);
      $display("past the size limit, %0d long output stalls, %0d mismatches.", hold_count,
               sb.errors);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
